>>> rtl/qtu_pkg.sv
// shared constants, control word layout and microcode rom for the q table update core
`default_nettype none

package qtu_pkg;

  localparam int unsigned REG_W      = 9;
  localparam int unsigned STATE_IN_W = 4;
  localparam int unsigned REWARD_W   = 11;
  localparam int unsigned FRAC_W     = 8;
  localparam int unsigned ROUND      = 1 << (FRAC_W - 1);

  localparam logic [REG_W-1:0] LEARN_RATE_RST = 9'd205;
  localparam logic [REG_W-1:0] DISCOUNT_RST   = 9'd243;

  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_LEARN_RATE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_DISCOUNT   = 1'b1;

  localparam int unsigned UPC_W = 3;
  typedef logic [UPC_W-1:0] upc_t;

  localparam upc_t STEP_IDLE = 3'd0;
  localparam upc_t STEP_SCAN = 3'd1;
  localparam upc_t STEP_OLD  = 3'd2;
  localparam upc_t STEP_MUL1 = 3'd3;
  localparam upc_t STEP_TGT  = 3'd4;
  localparam upc_t STEP_MUL2 = 3'd5;
  localparam upc_t STEP_UPD  = 3'd6;
  localparam upc_t STEP_CLR  = 3'd7;

  typedef enum logic [2:0] {
    COND_NEVER     = 3'd0,
    COND_ALWAYS    = 3'd1,
    COND_NO_IN     = 3'd2,
    COND_SCAN_MORE = 3'd3,
    COND_CLR_MORE  = 3'd4,
    COND_OUT_BUSY  = 3'd5
  } cond_e;

  typedef struct packed {
    cond_e cond;
    upc_t  target;
    logic  in_rdy;
    logic  rd_scan;
    logic  rd_old;
    logic  mul_gamma;
    logic  ld_tgt;
    logic  mul_lr;
    logic  upd;
    logic  clr_wr;
  } ctrl_t;

  typedef struct packed {
    logic in_valid;
    logic scan_last;
    logic clr_last;
    logic out_busy;
  } stat_t;

  // microcode rom, one control word per step
  function automatic ctrl_t ucode(upc_t upc);
    ctrl_t w;
    w = '0;
    unique case (upc)
      STEP_IDLE: begin
        w.in_rdy = 1'b1;
        w.cond   = COND_NO_IN;
        w.target = STEP_IDLE;
      end
      STEP_SCAN: begin
        w.rd_scan = 1'b1;
        w.cond    = COND_SCAN_MORE;
        w.target  = STEP_SCAN;
      end
      STEP_OLD: begin
        w.rd_old = 1'b1;
        w.cond   = COND_NEVER;
        w.target = STEP_OLD;
      end
      STEP_MUL1: begin
        w.mul_gamma = 1'b1;
        w.cond      = COND_NEVER;
        w.target    = STEP_MUL1;
      end
      STEP_TGT: begin
        w.ld_tgt = 1'b1;
        w.cond   = COND_NEVER;
        w.target = STEP_TGT;
      end
      STEP_MUL2: begin
        w.mul_lr = 1'b1;
        w.cond   = COND_OUT_BUSY;
        w.target = STEP_MUL2;
      end
      STEP_UPD: begin
        w.upd    = 1'b1;
        w.cond   = COND_ALWAYS;
        w.target = STEP_IDLE;
      end
      STEP_CLR: begin
        // falls through to the idle step by wrapping the step counter
        w.clr_wr = 1'b1;
        w.cond   = COND_CLR_MORE;
        w.target = STEP_CLR;
      end
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

>>> rtl/qtu_ram.sv
// generic simple dual port ram with registered read
`default_nettype none

module qtu_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

>>> rtl/qtu_seq.sv
// microcode sequencer: step counter, rom lookup and conditional jumps
`default_nettype none

module qtu_seq (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire qtu_pkg::stat_t stat_i,
  output qtu_pkg::ctrl_t      ctrl_o
);

  qtu_pkg::upc_t  upc_q, upc_d;
  qtu_pkg::ctrl_t ctrl;
  logic           jump;

  always_comb begin
    ctrl = qtu_pkg::ucode(upc_q);
    unique case (ctrl.cond)
      qtu_pkg::COND_NEVER:     jump = 1'b0;
      qtu_pkg::COND_ALWAYS:    jump = 1'b1;
      qtu_pkg::COND_NO_IN:     jump = !stat_i.in_valid;
      qtu_pkg::COND_SCAN_MORE: jump = !stat_i.scan_last;
      qtu_pkg::COND_CLR_MORE:  jump = !stat_i.clr_last;
      qtu_pkg::COND_OUT_BUSY:  jump = stat_i.out_busy;
      default:                 jump = 1'b0;
    endcase
    upc_d = jump ? ctrl.target : qtu_pkg::upc_t'(upc_q + qtu_pkg::upc_t'(1));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q <= qtu_pkg::STEP_CLR;
    end else begin
      upc_q <= upc_d;
    end
  end

  assign ctrl_o = ctrl;

endmodule

`default_nettype wire

>>> rtl/qtu_dp.sv
// datapath: table memory, row scan, two multiplies, saturating update and output register
`default_nettype none

module qtu_dp #(
  parameter int unsigned NUM_STATES  = 16,
  parameter int unsigned VALUE_WIDTH = 24
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire qtu_pkg::ctrl_t                      ctrl_i,
  output qtu_pkg::stat_t                           stat_o,
  input  wire logic                                cfg_we_i,
  input  wire logic [qtu_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  wire logic [qtu_pkg::REG_W-1:0]           cfg_wdata_i,
  input  wire logic                                in_valid_i,
  input  wire logic [qtu_pkg::STATE_IN_W-1:0]      cur_state_i,
  input  wire logic [qtu_pkg::STATE_IN_W-1:0]      chosen_action_i,
  input  wire logic signed [qtu_pkg::REWARD_W-1:0] reward_i,
  input  wire logic                                out_ready_i,
  output logic                                     out_valid_o,
  output logic signed [VALUE_WIDTH-1:0]            new_value_o,
  output logic [VALUE_WIDTH-2:0]                   row_max_o
);

  localparam int unsigned VW     = VALUE_WIDTH;
  localparam int unsigned ST_W   = $clog2(NUM_STATES);
  localparam int unsigned ADDR_W = 2 * ST_W;
  localparam int unsigned DEPTH  = 1 << ADDR_W;
  localparam int unsigned IN_N   = 1 << qtu_pkg::STATE_IN_W;
  localparam int unsigned FW     = qtu_pkg::FRAC_W;
  localparam int unsigned P1_W   = qtu_pkg::REG_W + VW - 1;
  localparam int unsigned SC_W   = P1_W + 1 - FW;
  localparam int unsigned TW     = VW + 4;
  localparam int unsigned P2_W   = qtu_pkg::REG_W + 1 + TW;
  localparam int unsigned DL_W   = P2_W - FW;
  localparam int unsigned SUM_W  = DL_W + 1;
  localparam int unsigned RW     = qtu_pkg::REWARD_W;

  // index wrap table, input index modulo NUM_STATES
  logic [ST_W-1:0] wrap_tab [IN_N];
  for (genvar g = 0; g < IN_N; g++) begin : g_wrap
    assign wrap_tab[g] = ST_W'(g % NUM_STATES);
  end

  logic [qtu_pkg::REG_W-1:0] lr_q, disc_q;
  logic [ADDR_W-1:0]         cnt_q;
  logic                      scan_vld_q;
  logic                      out_valid_q;
  logic [ST_W-1:0]           s_q, a_q;
  logic signed [RW-1:0]      reward_q;
  logic [VW-2:0]             max_q;
  logic signed [VW-1:0]      old_q;
  logic [P1_W-1:0]           prod1_q;
  logic signed [TW-1:0]      tgt_q;
  logic signed [P2_W-1:0]    prod2_q;
  logic signed [VW-1:0]      new_value_q;
  logic [VW-2:0]             row_max_q;

  logic                      in_acc;
  logic                      ram_we, ram_re;
  logic [ADDR_W-1:0]         ram_waddr, ram_raddr;
  logic [VW-1:0]             ram_wdata, ram_rdata;
  logic [P1_W:0]             rnd1;
  logic [SC_W-1:0]           scaled;
  logic signed [TW-1:0]      tgt_d;
  logic signed [P2_W-1:0]    rnd2;
  logic signed [DL_W-1:0]    delta;
  logic signed [SUM_W-1:0]   sum;
  logic signed [SUM_W-1:0]   vmax_ext, vmin_ext;
  logic signed [VW-1:0]      sat_val;

  assign in_acc = ctrl_i.in_rdy & in_valid_i;

  // memory port selection
  always_comb begin
    ram_re    = ctrl_i.rd_scan | ctrl_i.rd_old;
    ram_raddr = ctrl_i.rd_old ? {s_q, a_q} : {a_q, cnt_q[ST_W-1:0]};
    ram_we    = ctrl_i.clr_wr | ctrl_i.upd;
    ram_waddr = ctrl_i.clr_wr ? cnt_q : {s_q, a_q};
    ram_wdata = ctrl_i.clr_wr ? '0 : sat_val;
  end

  qtu_ram #(
    .WIDTH (VW),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // arithmetic
  always_comb begin
    rnd1   = {1'b0, prod1_q} + (P1_W + 1)'(qtu_pkg::ROUND);
    scaled = rnd1[P1_W:FW];
    tgt_d  = $signed({{(TW - RW - FW){reward_q[RW-1]}}, reward_q, {FW{1'b0}}})
           + $signed({{(TW - SC_W){1'b0}}, scaled})
           - $signed({{(TW - VW){old_q[VW-1]}}, old_q});
    rnd2   = prod2_q + P2_W'(qtu_pkg::ROUND);
    delta  = rnd2[P2_W-1:FW];
    sum    = $signed({{(SUM_W - VW){old_q[VW-1]}}, old_q})
           + $signed({delta[DL_W-1], delta});
    vmax_ext = $signed({{(SUM_W - VW + 1){1'b0}}, {(VW - 1){1'b1}}});
    vmin_ext = $signed({{(SUM_W - VW + 1){1'b1}}, {(VW - 1){1'b0}}});
    if (sum > vmax_ext) begin
      sat_val = $signed({1'b0, {(VW - 1){1'b1}}});
    end else if (sum < vmin_ext) begin
      sat_val = $signed({1'b1, {(VW - 1){1'b0}}});
    end else begin
      sat_val = sum[VW-1:0];
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lr_q        <= qtu_pkg::LEARN_RATE_RST;
      disc_q      <= qtu_pkg::DISCOUNT_RST;
      cnt_q       <= '0;
      scan_vld_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          qtu_pkg::CFG_LEARN_RATE: lr_q   <= cfg_wdata_i;
          qtu_pkg::CFG_DISCOUNT:   disc_q <= cfg_wdata_i;
          default: ;
        endcase
      end
      if (in_acc) begin
        cnt_q <= '0;
      end else if (ctrl_i.rd_scan || ctrl_i.clr_wr) begin
        cnt_q <= cnt_q + ADDR_W'(1);
      end
      scan_vld_q <= ctrl_i.rd_scan;
      if (ctrl_i.upd) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s_q      <= wrap_tab[cur_state_i];
      a_q      <= wrap_tab[chosen_action_i];
      reward_q <= reward_i;
      max_q    <= '0;
    end else if (scan_vld_q && ($signed(ram_rdata) > $signed({1'b0, max_q}))) begin
      max_q <= ram_rdata[VW-2:0];
    end
    if (ctrl_i.mul_gamma) begin
      old_q   <= ram_rdata;
      prod1_q <= P1_W'(disc_q) * P1_W'(max_q);
    end
    if (ctrl_i.ld_tgt) begin
      tgt_q <= tgt_d;
    end
    if (ctrl_i.mul_lr) begin
      prod2_q <= P2_W'($signed({1'b0, lr_q})) * P2_W'(tgt_q);
    end
    if (ctrl_i.upd) begin
      new_value_q <= sat_val;
      row_max_q   <= max_q;
    end
  end

  always_comb begin
    stat_o.in_valid  = in_valid_i;
    stat_o.scan_last = (cnt_q[ST_W-1:0] == ST_W'(NUM_STATES - 1));
    stat_o.clr_last  = &cnt_q;
    stat_o.out_busy  = out_valid_q & ~out_ready_i;
  end

  assign out_valid_o = out_valid_q;
  assign new_value_o = new_value_q;
  assign row_max_o   = row_max_q;

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.upd |-> !out_valid_q)
    else $error("update step reached with a result word still pending");

  a_valid_from_upd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(ctrl_i.upd))
    else $error("result raised outside the update step");

  a_upd_after_mul: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.upd |-> $past(ctrl_i.mul_lr))
    else $error("update step not preceded by the learning rate multiply");

  a_single_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !ctrl_i.in_rdy)
    else $error("second word accepted straight after an accept");

endmodule

`default_nettype wire

>>> rtl/q_table_update_core.sv
// top level of the tabular q learning update core
// a new word is taken only after the last one has been written back, as the row scan runs
//   through the single read port of the table memory and is followed by the two multiplies
// a result not taken holds the sequencer in the second multiply step until it is taken
// reset: config registers return to 205 and 243, then a clearing pass writes zero to every
//   table entry, with in_ready_o low
`default_nettype none

module q_table_update_core #(
  parameter int unsigned NUM_STATES  = 16,
  parameter int unsigned VALUE_WIDTH = 24
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  // configuration write port
  input  wire logic                                cfg_we_i,
  input  wire logic [qtu_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  wire logic [qtu_pkg::REG_W-1:0]           cfg_wdata_i,
  // input channel
  input  wire logic                                in_valid_i,
  output logic                                     in_ready_o,
  input  wire logic [qtu_pkg::STATE_IN_W-1:0]      cur_state_i,
  input  wire logic [qtu_pkg::STATE_IN_W-1:0]      chosen_action_i,
  input  wire logic signed [qtu_pkg::REWARD_W-1:0] reward_i,
  // result channel
  output logic                                     out_valid_o,
  input  wire logic                                out_ready_i,
  output logic signed [VALUE_WIDTH-1:0]            new_value_o,
  output logic [VALUE_WIDTH-2:0]                   row_max_o
);

  // control word from the microcode rom, status back from the datapath
  qtu_pkg::ctrl_t ctrl;
  qtu_pkg::stat_t stat;

  // step counter and rom: idle, row scan loop, read old entry, gamma multiply,
  // target, learning rate multiply, write back; the clearing loop runs after reset
  qtu_seq u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (stat),
    .ctrl_o (ctrl)
  );

  // table memory, max register, multiplier stages and the output register
  qtu_dp #(
    .NUM_STATES  (NUM_STATES),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .ctrl_i          (ctrl),
    .stat_o          (stat),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .cur_state_i     (cur_state_i),
    .chosen_action_i (chosen_action_i),
    .reward_i        (reward_i),
    .out_ready_i     (out_ready_i),
    .out_valid_o     (out_valid_o),
    .new_value_o     (new_value_o),
    .row_max_o       (row_max_o)
  );

  // ready only in the idle step; a pending result does not block the next word
  assign in_ready_o = ctrl.in_rdy;

endmodule

`default_nettype wire

>>> tb/sv/tb_q_table_update_core.sv
// self-checking testbench for the q table update core: directed and random words against a shadow table
module tb_q_table_update_core;

  localparam int unsigned NUM_STATES  = 16;
  localparam int unsigned VALUE_WIDTH = 24;
  localparam longint      VAL_MAX     = (longint'(1) << (VALUE_WIDTH - 1)) - 1;
  localparam longint      VAL_MIN     = -VAL_MAX - 1;
  // worst case is far below this even with long stalls on both sides
  localparam int          CYCLE_LIMIT = 600000;
  localparam int          SEG_WORDS   = 100;
  localparam int          NUM_SEGS    = 8;

  // one expected result word
  typedef struct packed {
    logic signed [VALUE_WIDTH-1:0] new_value;
    logic [VALUE_WIDTH-2:0]        row_max;
  } q_result_t;

  typedef enum logic {ROW_WORD, ROW_REG} row_kind_e;

  // directed stimulus row: either an update word or a register write
  typedef struct packed {
    row_kind_e                              kind;
    logic [qtu_pkg::STATE_IN_W-1:0]         st;
    logic [qtu_pkg::STATE_IN_W-1:0]         act;
    logic signed [qtu_pkg::REWARD_W-1:0]    rw;
    logic                                   typed;
    logic signed [VALUE_WIDTH-1:0]          t_nv;
    logic [VALUE_WIDTH-2:0]                 t_mx;
    logic [qtu_pkg::CFG_IDX_W-1:0]          reg_idx;
    logic [qtu_pkg::REG_W-1:0]              reg_val;
  } plan_row_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_we_i;
  logic [qtu_pkg::CFG_IDX_W-1:0] cfg_idx_i;
  logic [qtu_pkg::REG_W-1:0] cfg_wdata_i;
  logic in_valid_i;
  logic in_ready_o;
  logic [qtu_pkg::STATE_IN_W-1:0] cur_state_i;
  logic [qtu_pkg::STATE_IN_W-1:0] chosen_action_i;
  logic signed [qtu_pkg::REWARD_W-1:0] reward_i;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic signed [VALUE_WIDTH-1:0] new_value_o;
  logic [VALUE_WIDTH-2:0] row_max_o;

  // shadow copy of the table and the two gain registers
  longint q_shadow [NUM_STATES*NUM_STATES];
  logic [qtu_pkg::REG_W-1:0] learn_rate_reg;
  logic [qtu_pkg::REG_W-1:0] discount_reg;

  q_result_t expected_results [$];

  // hand-typed expectation for the word currently offered
  logic typed_word;
  q_result_t typed_result;

  int tx_idle_pct;
  int rx_idle_pct;
  int mismatches;
  int words_in;
  int results_checked;
  int regs_written;
  int saturated;
  int cycle_count;

  // directed part: reset gains first, then the extremes of both registers,
  // saturation at both ends, zero gain and the diagonal case
  plan_row_t directed_plan [27] = '{
    // empty table: nothing moves with a zero reward
    '{ROW_WORD, 0, 0, 0, 1'b1, 0, 0, qtu_pkg::CFG_LEARN_RATE, 0},
    // largest reward into an empty row, 205 * 1023
    '{ROW_WORD, 15, 15, 1023, 1'b1, 209715, 0, qtu_pkg::CFG_LEARN_RATE, 0},
    // state equals action: the row max is read before the write
    '{ROW_WORD, 15, 15, 1023, 1'b0, 0, 0, qtu_pkg::CFG_LEARN_RATE, 0},
    // most negative reward, 205 * -1024
    '{ROW_WORD, 0, 0, -1024, 1'b1, -209920, 0, qtu_pkg::CFG_LEARN_RATE, 0},
    // scanned row holds only a negative entry and zeros: max floors at zero
    '{ROW_WORD, 1, 0, -1024, 1'b1, -209920, 0, qtu_pkg::CFG_LEARN_RATE, 0},
    '{ROW_WORD, 2, 15, 0, 1'b0, 0, 0, qtu_pkg::CFG_LEARN_RATE, 0},
    '{ROW_WORD, 10, 5, 1, 1'b0, 0, 0, qtu_pkg::CFG_LEARN_RATE, 0},
    '{ROW_WORD, 5, 10, -1, 1'b0, 0, 0, qtu_pkg::CFG_LEARN_RATE, 0},
    // unity gains
    '{ROW_REG, 0, 0, 0, 1'b0, 0, 0, qtu_pkg::CFG_LEARN_RATE, 256},
    '{ROW_REG, 0, 0, 0, 1'b0, 0, 0, qtu_pkg::CFG_DISCOUNT, 256},
    '{ROW_WORD, 3, 15, 100, 1'b0, 0, 0, qtu_pkg::CFG_LEARN_RATE, 0},
    // gains near two: the diagonal entry runs into positive saturation
    '{ROW_REG, 0, 0, 0, 1'b0, 0, 0, qtu_pkg::CFG_LEARN_RATE, 511},
    '{ROW_REG, 0, 0, 0, 1'b0, 0, 0, qtu_pkg::CFG_DISCOUNT, 511},
    '{ROW_WORD, 7, 7, 1023, 1'b0, 0, 0, qtu_pkg::CFG_LEARN_RATE, 0},
    '{ROW_WORD, 7, 7, 1023, 1'b0, 0, 0, qtu_pkg::CFG_LEARN_RATE, 0},
    '{ROW_WORD, 7, 7, 1023, 1'b0, 0, 0, qtu_pkg::CFG_LEARN_RATE, 0},
    '{ROW_WORD, 7, 7, 1023, 1'b0, 0, 0, qtu_pkg::CFG_LEARN_RATE, 0},
    '{ROW_WORD, 7, 7, 1023, 1'b0, 0, 0, qtu_pkg::CFG_LEARN_RATE, 0},
    '{ROW_WORD, 6, 7, 1023, 1'b0, 0, 0, qtu_pkg::CFG_LEARN_RATE, 0},
    // no discount: a full entry overshoots into negative saturation
    '{ROW_REG, 0, 0, 0, 1'b0, 0, 0, qtu_pkg::CFG_DISCOUNT, 0},
    '{ROW_WORD, 6, 7, -1024, 1'b0, 0, 0, qtu_pkg::CFG_LEARN_RATE, 0},
    // zero learning rate leaves the entry alone
    '{ROW_REG, 0, 0, 0, 1'b0, 0, 0, qtu_pkg::CFG_LEARN_RATE, 0},
    '{ROW_WORD, 9, 9, -1024, 1'b0, 0, 0, qtu_pkg::CFG_LEARN_RATE, 0},
    '{ROW_REG, 0, 0, 0, 1'b0, 0, 0, qtu_pkg::CFG_LEARN_RATE, 1},
    '{ROW_REG, 0, 0, 0, 1'b0, 0, 0, qtu_pkg::CFG_DISCOUNT, 1},
    '{ROW_WORD, 12, 3, -512, 1'b0, 0, 0, qtu_pkg::CFG_LEARN_RATE, 0},
    '{ROW_WORD, 3, 12, 511, 1'b0, 0, 0, qtu_pkg::CFG_LEARN_RATE, 0}
  };

  // gains per random segment, -1 picks a random value
  int seg_lr [NUM_SEGS]   = '{205, 256, 511, 0, 1, -1, 128, -1};
  int seg_disc [NUM_SEGS] = '{243, 256, 511, 128, 0, -1, 511, -1};

  q_table_update_core #(
    .NUM_STATES (NUM_STATES),
    .VALUE_WIDTH(VALUE_WIDTH)
  ) i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .cur_state_i    (cur_state_i),
    .chosen_action_i(chosen_action_i),
    .reward_i       (reward_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .new_value_o    (new_value_o),
    .row_max_o      (row_max_o)
  );

  always #5 clk_i = ~clk_i;

  // q update on the shadow table: scan the action row, floor at zero,
  // then move the entry toward reward + discount * max with round-half-up shifts
  function automatic void apply_q_update(input logic [qtu_pkg::STATE_IN_W-1:0] st,
                                         input logic [qtu_pkg::STATE_IN_W-1:0] act,
                                         input logic signed [qtu_pkg::REWARD_W-1:0] rw,
                                         output q_result_t res);
    longint best;
    longint old;
    longint target;
    longint delta;
    longint upd;
    longint rw_l;
    int unsigned slot;
    best = 0;
    rw_l = rw;
    for (int j = 0; j < NUM_STATES; j++) begin
      if (q_shadow[(act % NUM_STATES) * NUM_STATES + j] > best) begin
        best = q_shadow[(act % NUM_STATES) * NUM_STATES + j];
      end
    end
    slot   = (st % NUM_STATES) * NUM_STATES + (act % NUM_STATES);
    old    = q_shadow[slot];
    // arithmetic shifts on longint floor, so +128 gives ties toward plus infinity
    target = rw_l * 256 + ((longint'(discount_reg) * best + 128) >>> 8) - old;
    delta  = (longint'(learn_rate_reg) * target + 128) >>> 8;
    upd    = old + delta;
    if (upd > VAL_MAX) begin
      upd = VAL_MAX;
    end else if (upd < VAL_MIN) begin
      upd = VAL_MIN;
    end
    q_shadow[slot] = upd;
    res.new_value  = upd[VALUE_WIDTH-1:0];
    res.row_max    = best[VALUE_WIDTH-2:0];
  endfunction

  // everything seen at the rising edge: register writes, accepted words,
  // accepted results and the cycle limit
  always @(posedge clk_i) begin : watch_ports
    q_result_t got_exp;
    q_result_t predicted;
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               expected_results.size());
      $display("FAILURE");
      $finish;
    end else if (rst_ni) begin
      if (cfg_we_i) begin
        regs_written++;
        case (cfg_idx_i)
          qtu_pkg::CFG_LEARN_RATE: learn_rate_reg = cfg_wdata_i;
          qtu_pkg::CFG_DISCOUNT:   discount_reg   = cfg_wdata_i;
          default: ;
        endcase
      end
      // results first: they always belong to earlier words
      if (out_valid_o && out_ready_i) begin
        if (expected_results.size() == 0) begin
          $error("result with no word outstanding: new_value %0d row_max %0d",
                 new_value_o, row_max_o);
          mismatches++;
        end else begin
          got_exp = expected_results.pop_front();
          results_checked++;
          if (new_value_o !== got_exp.new_value) begin
            $error("new_value: expected %0d, got %0d", $signed(got_exp.new_value), new_value_o);
            mismatches++;
          end
          if (row_max_o !== got_exp.row_max) begin
            $error("row_max: expected %0d, got %0d", got_exp.row_max, row_max_o);
            mismatches++;
          end
        end
      end
      if (in_valid_i && in_ready_o) begin
        words_in++;
        apply_q_update(cur_state_i, chosen_action_i, reward_i, predicted);
        if (predicted.new_value == {1'b0, {(VALUE_WIDTH-1){1'b1}}} ||
            predicted.new_value == {1'b1, {(VALUE_WIDTH-1){1'b0}}}) begin
          saturated++;
        end
        // a hand-typed row overrides the shadow, which still tracks the table
        expected_results.push_back(typed_word ? typed_result : predicted);
      end
    end
  end

  // receiver back-pressure, redrawn every cycle
  always @(negedge clk_i) begin
    out_ready_i = ($urandom_range(99) >= rx_idle_pct);
  end

  // offer one word, idling first at the current rate; returns on a falling edge
  task automatic send_word(input logic [qtu_pkg::STATE_IN_W-1:0] st,
                           input logic [qtu_pkg::STATE_IN_W-1:0] act,
                           input logic signed [qtu_pkg::REWARD_W-1:0] rw,
                           input logic typed,
                           input logic signed [VALUE_WIDTH-1:0] t_nv,
                           input logic [VALUE_WIDTH-2:0] t_mx);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i             = 1'b1;
    cur_state_i            = st;
    chosen_action_i        = act;
    reward_i               = rw;
    typed_word             = typed;
    typed_result.new_value = t_nv;
    typed_result.row_max   = t_mx;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // sender holds off until every outstanding result is back
  task automatic drain_results();
    in_valid_i = 1'b0;
    while (expected_results.size() != 0) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [qtu_pkg::CFG_IDX_W-1:0] idx,
                           input logic [qtu_pkg::REG_W-1:0] val);
    cfg_we_i    = 1'b1;
    cfg_idx_i   = idx;
    cfg_wdata_i = val;
    @(negedge clk_i);
    cfg_we_i    = 1'b0;
  endtask

  initial begin : stimulus
    logic [qtu_pkg::STATE_IN_W-1:0] st;
    logic [qtu_pkg::STATE_IN_W-1:0] act;
    logic signed [qtu_pkg::REWARD_W-1:0] rw;
    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_idx_i       = qtu_pkg::CFG_LEARN_RATE;
    cfg_wdata_i     = '0;
    in_valid_i      = 1'b0;
    cur_state_i     = '0;
    chosen_action_i = '0;
    reward_i        = '0;
    typed_word      = 1'b0;
    typed_result    = '0;
    mismatches      = 0;
    words_in        = 0;
    results_checked = 0;
    regs_written    = 0;
    saturated       = 0;
    cycle_count     = 0;
    learn_rate_reg  = qtu_pkg::LEARN_RATE_RST;
    discount_reg    = qtu_pkg::DISCOUNT_RST;
    foreach (q_shadow[k]) q_shadow[k] = 0;
    // sender idles more lightly than the receiver to begin with
    tx_idle_pct = 35;
    rx_idle_pct = 45;

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed rows; the clearing pass after reset just shows up as a long wait for ready
    foreach (directed_plan[i]) begin
      if (directed_plan[i].kind == ROW_REG) begin
        drain_results();
        write_reg(directed_plan[i].reg_idx, directed_plan[i].reg_val);
      end else begin
        send_word(directed_plan[i].st, directed_plan[i].act, directed_plan[i].rw,
                  directed_plan[i].typed, directed_plan[i].t_nv, directed_plan[i].t_mx);
      end
    end

    // random segments, each with its own pair of gains
    for (int seg = 0; seg < NUM_SEGS; seg++) begin
      if (seg == 3) begin
        tx_idle_pct = 45;
        rx_idle_pct = 35;
      end else if (seg == 6) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      drain_results();
      write_reg(qtu_pkg::CFG_LEARN_RATE,
                (seg_lr[seg] < 0) ? $urandom_range(511) : seg_lr[seg]);
      write_reg(qtu_pkg::CFG_DISCOUNT,
                (seg_disc[seg] < 0) ? $urandom_range(511) : seg_disc[seg]);
      for (int n = 0; n < SEG_WORDS; n++) begin
        // mostly a small corner of the table so entries build up and saturate
        if ($urandom_range(9) < 6) begin
          st  = $urandom_range(3);
          act = $urandom_range(3);
        end else begin
          st  = $urandom;
          act = $urandom;
        end
        case ($urandom_range(9))
          0:       rw = 1023;
          1:       rw = -1024;
          default: rw = $urandom;
        endcase
        send_word(st, act, rw, 1'b0, '0, '0);
      end
    end

    drain_results();
    // let the last update step finish before closing
    repeat (40) @(posedge clk_i);

    $display("run covered %0d words over %0d register writes, %0d results checked",
             words_in, regs_written, results_checked);
    $display("%0d results hit a saturation bound, %0d mismatches", saturated, mismatches);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

>>> q_table_update_core.f
rtl/qtu_pkg.sv
rtl/qtu_ram.sv
rtl/qtu_seq.sv
rtl/qtu_dp.sv
rtl/q_table_update_core.sv
tb/sv/tb_q_table_update_core.sv
